// ===== rtl/mar_pkg.sv =====
`default_nettype none

package mar_pkg;

    // Default build of the readout
    localparam int CHANNELS_DEF    = 6;
    localparam int SAMPLE_BITS_DEF = 24;

    // Fixed port geometry
    localparam int MAX_CH       = 6;
    localparam int SAMPLE_OUT_W = 24;
    localparam int HALF_W       = 8;
    localparam int TIMEOUT_W    = 24;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;
    localparam int IN_W         = 8;
    localparam int FLAG_W       = 5;
    localparam int OUT_W        = 152;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READY_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_ENABLE  = 2'd2;

    // Configuration reset values
    localparam logic [HALF_W-1:0]    HALF_RESET    = 8'd1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd200000;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_WAIT = 4'b0010,
        PH_HIGH = 4'b0100,
        PH_LOW  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic clear;
        logic shift;
    } t_shift_ctl;

endpackage

`default_nettype wire

// ===== rtl/mar_shift.sv =====
`default_nettype none

module mar_shift #(
    parameter int CHANNELS    = mar_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = mar_pkg::SAMPLE_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_step,
    input  wire  mar_pkg::t_shift_ctl       i_ctl,
    input  wire  [mar_pkg::MAX_CH-1:0]      i_lines,
    output logic [mar_pkg::SAMPLE_OUT_W-1:0] o_sample [mar_pkg::MAX_CH]
);

    logic [SAMPLE_BITS-1:0] r_shift [CHANNELS];
    logic [SAMPLE_BITS-1:0] n_shift [CHANNELS];

    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            n_shift[k] = r_shift[k];
            if (i_step && i_ctl.clear) begin
                n_shift[k] = '0;
            end else if (i_step && i_ctl.shift) begin
                n_shift[k] = {r_shift[k][SAMPLE_BITS-2:0], i_lines[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CHANNELS; k++) begin
            if (!i_rst_n) begin
                r_shift[k] <= '0;
            end else begin
                r_shift[k] <= n_shift[k];
            end
        end
    end

    // Present the updated value, sign-extended or cut to the port width
    for (genvar g = 0; g < mar_pkg::MAX_CH; g++) begin : g_out
        if (g < CHANNELS) begin : g_used
            if (SAMPLE_BITS >= mar_pkg::SAMPLE_OUT_W) begin : g_cut
                assign o_sample[g] = n_shift[g][mar_pkg::SAMPLE_OUT_W-1:0];
            end else begin : g_ext
                assign o_sample[g] = {{(mar_pkg::SAMPLE_OUT_W-SAMPLE_BITS)
                                       {n_shift[g][SAMPLE_BITS-1]}}, n_shift[g]};
            end
        end else begin : g_unused
            assign o_sample[g] = '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mar_seq.sv =====
`default_nettype none

module mar_seq #(
    parameter int SAMPLE_BITS = mar_pkg::SAMPLE_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_step,
    input  wire                              i_start,
    input  wire                              i_line0,
    input  wire  [mar_pkg::HALF_W-1:0]       i_half_ticks,
    input  wire  [mar_pkg::TIMEOUT_W-1:0]    i_timeout_ticks,
    output mar_pkg::t_shift_ctl              o_shift_ctl,
    output logic                             o_clock,
    output logic                             o_busy,
    output logic                             o_valid,
    output logic                             o_timeout
);

    localparam int PW = $clog2(SAMPLE_BITS + 2);
    localparam logic [PW-1:0] LAST_BIT = PW'(SAMPLE_BITS);

    mar_pkg::t_phase                r_phase, n_phase;
    logic [PW-1:0]                  r_pulse, n_pulse;
    logic [mar_pkg::HALF_W-1:0]     r_half, n_half, w_half_inc;
    logic [mar_pkg::TIMEOUT_W-1:0]  r_wait, n_wait;
    logic                           r_clock, n_clock;

    assign w_half_inc = r_half + 1'b1;

    always_comb begin
        n_phase     = r_phase;
        n_pulse     = r_pulse;
        n_half      = r_half;
        n_wait      = r_wait;
        n_clock     = r_clock;
        o_shift_ctl = '0;
        o_valid     = 1'b0;
        o_timeout   = 1'b0;
        if (i_step) begin
            case (r_phase)
                mar_pkg::PH_IDLE: begin
                    if (i_start) begin
                        n_phase = mar_pkg::PH_WAIT;
                        n_wait  = '0;
                    end
                end
                mar_pkg::PH_WAIT: begin
                    if (!i_line0) begin
                        o_shift_ctl.clear = 1'b1;
                        n_pulse = '0;
                        n_half  = '0;
                        n_clock = 1'b1;
                        n_phase = mar_pkg::PH_HIGH;
                    end else if (r_wait >= i_timeout_ticks) begin
                        o_timeout = 1'b1;
                        n_phase   = mar_pkg::PH_IDLE;
                    end else begin
                        n_wait = r_wait + 1'b1;
                    end
                end
                mar_pkg::PH_HIGH: begin
                    n_half = w_half_inc;
                    if (w_half_inc >= i_half_ticks) begin
                        // sample on the tick that ends the high phase
                        o_shift_ctl.shift = (r_pulse < LAST_BIT);
                        n_pulse = r_pulse + 1'b1;
                        n_half  = '0;
                        n_clock = 1'b0;
                        n_phase = mar_pkg::PH_LOW;
                    end
                end
                mar_pkg::PH_LOW: begin
                    n_half = w_half_inc;
                    if (w_half_inc >= i_half_ticks) begin
                        n_half = '0;
                        if (r_pulse <= LAST_BIT) begin
                            n_clock = 1'b1;
                            n_phase = mar_pkg::PH_HIGH;
                        end else begin
                            o_valid = 1'b1;
                            n_phase = mar_pkg::PH_IDLE;
                        end
                    end
                end
                default: begin
                    n_phase = mar_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mar_pkg::PH_IDLE;
            r_pulse <= '0;
            r_half  <= '0;
            r_wait  <= '0;
            r_clock <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pulse <= n_pulse;
            r_half  <= n_half;
            r_wait  <= n_wait;
            r_clock <= n_clock;
        end
    end

    assign o_clock = n_clock;
    assign o_busy  = (n_phase != mar_pkg::PH_IDLE);

    a_clock_in_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clock == (r_phase == mar_pkg::PH_HIGH))
        else $error("serial clock level disagrees with phase");

    a_pulse_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pulse <= LAST_BIT + 1'b1)
        else $error("pulse count beyond last pulse");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid || o_timeout) |=> (r_phase == mar_pkg::PH_IDLE))
        else $error("sequencer not idle after completion or timeout");

    a_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_timeout))
        else $error("valid and timeout in the same tick");

endmodule

`default_nettype wire

// ===== rtl/multi_adc_serial_readout.sv =====
// Path: an item is held in the input register, and the sequencer step writes its result
// into the output register; a stalled receiver holds both registers.
// Throughput: one item per cycle while the receiver is ready; the input register
// refills while the output register is taken, so both sides stream without bubbles.
// Reset (synchronous, active low): sequencer idle, clock low, samples zero, no item held,
// configuration back to half period 1, timeout 200000, power enabled.
`default_nettype none

module multi_adc_serial_readout #(
    parameter int CHANNELS    = mar_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = mar_pkg::SAMPLE_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // bit 0 start_req, bits 6:1 data_lines, bit 7 zero
    input  wire  [mar_pkg::IN_W-1:0]           s_axis_tdata,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // bit 0 serial_clock, 1 power_pin, 2 busy_res, 3 sample_valid, 4 ready_timeout,
    // then sample_ch0..sample_ch5 at 24 bits each from bit 5, bits 151:149 zero
    output logic [mar_pkg::OUT_W-1:0]          m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [mar_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [mar_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PAD_W = mar_pkg::OUT_W - mar_pkg::FLAG_W
                           - mar_pkg::MAX_CH * mar_pkg::SAMPLE_OUT_W;

    // Configuration registers
    logic [mar_pkg::HALF_W-1:0]    r_half_ticks;
    logic [mar_pkg::TIMEOUT_W-1:0] r_timeout_ticks;
    logic                          r_power_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_ticks    <= mar_pkg::HALF_RESET;
            r_timeout_ticks <= mar_pkg::TIMEOUT_RESET;
            r_power_en      <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mar_pkg::REG_HALF_PERIOD:   r_half_ticks    <= i_cfg_data[mar_pkg::HALF_W-1:0];
                mar_pkg::REG_READY_TIMEOUT: r_timeout_ticks <= i_cfg_data;
                mar_pkg::REG_POWER_ENABLE:  r_power_en      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    logic                       r_in_valid;
    logic                       r_in_start;
    logic [mar_pkg::MAX_CH-1:0] r_in_lines;
    logic                       w_step;
    logic                       r_out_valid;

    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_start <= s_axis_tdata[0];
            r_in_lines <= s_axis_tdata[mar_pkg::MAX_CH:1];
        end
    end

    // Sequencer and sample registers
    mar_pkg::t_shift_ctl            w_shift_ctl;
    logic                           w_clock, w_busy, w_valid, w_timeout;
    logic [mar_pkg::SAMPLE_OUT_W-1:0] w_sample [mar_pkg::MAX_CH];

    mar_seq #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_start         (r_in_start),
        .i_line0         (r_in_lines[0]),
        .i_half_ticks    (r_half_ticks),
        .i_timeout_ticks (r_timeout_ticks),
        .o_shift_ctl     (w_shift_ctl),
        .o_clock         (w_clock),
        .o_busy          (w_busy),
        .o_valid         (w_valid),
        .o_timeout       (w_timeout)
    );

    mar_shift #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_shift (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_ctl    (w_shift_ctl),
        .i_lines  (r_in_lines),
        .o_sample (w_sample)
    );

    // Result register
    logic [mar_pkg::OUT_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_data <= {{PAD_W{1'b0}},
                           w_sample[5], w_sample[4], w_sample[3],
                           w_sample[2], w_sample[1], w_sample[0],
                           w_timeout, w_valid, w_busy, r_power_en, w_clock};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;

    import mar_pkg::*;

    localparam int LIMIT       = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int LATENCY     = 4;
    localparam int MAX_REPORTS = 40;

    // Same layout as m_axis_tdata[148:0], lowest field last
    typedef struct packed {
        logic [MAX_CH-1:0][SAMPLE_OUT_W-1:0] ch;
        logic                                tmo;
        logic                                done;
        logic                                busy;
        logic                                pwr;
        logic                                sclk;
    } readout_tick_t;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic [IN_W-1:0]       s_axis_tdata  = '0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    wire  [OUT_W-1:0]      m_axis_tdata;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    wire                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    multi_adc_serial_readout uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Sequencer copy: configuration and state
    logic [HALF_W-1:0]                   cfg_half;
    logic [TIMEOUT_W-1:0]                cfg_tmo;
    logic                                cfg_pwr;
    t_phase                              seq_phase;
    logic [4:0]                          seq_pulses;
    logic [HALF_W-1:0]                   seq_half_tmr;
    logic [TIMEOUT_W-1:0]                seq_wait_tmr;
    logic                                seq_clk;
    logic [MAX_CH-1:0][SAMPLE_OUT_W-1:0] seq_samples;

    logic [IN_W-1:0] ticks_pending[$];
    readout_tick_t   tick_results_due[$];

    int   ticks_queued   = 0;
    int   ticks_checked  = 0;
    int   readouts_done  = 0;
    int   timeouts_seen  = 0;
    int   mismatches     = 0;
    int   cycles         = 0;
    int   snd_idle_pct   = 0;
    int   rcv_idle_pct   = 0;
    int   hold_left      = 0;
    logic hold_req       = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic advance_sequencer(input logic start, input logic [5:0] lines);
        readout_tick_t r;
        int k;
        r = '0;
        case (seq_phase)
            PH_IDLE: begin
                if (start) begin
                    seq_phase    = PH_WAIT;
                    seq_wait_tmr = '0;
                end
            end
            PH_WAIT: begin
                if (!lines[0]) begin
                    seq_samples  = '0;
                    seq_pulses   = '0;
                    seq_half_tmr = '0;
                    seq_clk      = 1'b1;
                    seq_phase    = PH_HIGH;
                end else if (seq_wait_tmr >= cfg_tmo) begin
                    r.tmo     = 1'b1;
                    seq_phase = PH_IDLE;
                end else begin
                    seq_wait_tmr = seq_wait_tmr + 1'b1;
                end
            end
            PH_HIGH: begin
                seq_half_tmr = seq_half_tmr + 1'b1;
                if (seq_half_tmr >= cfg_half) begin
                    // sample at the end of the high phase, MSB first
                    if (seq_pulses < 5'd24) begin
                        for (k = 0; k < MAX_CH; k++)
                            seq_samples[k] = {seq_samples[k][SAMPLE_OUT_W-2:0], lines[k]};
                    end
                    seq_pulses   = seq_pulses + 1'b1;
                    seq_half_tmr = '0;
                    seq_clk      = 1'b0;
                    seq_phase    = PH_LOW;
                end
            end
            default: begin
                seq_half_tmr = seq_half_tmr + 1'b1;
                if (seq_half_tmr >= cfg_half) begin
                    seq_half_tmr = '0;
                    if (seq_pulses <= 5'd24) begin
                        seq_clk   = 1'b1;
                        seq_phase = PH_HIGH;
                    end else begin
                        r.done    = 1'b1;
                        seq_phase = PH_IDLE;
                    end
                end
            end
        endcase
        r.sclk = seq_clk;
        r.pwr  = cfg_pwr;
        r.busy = (seq_phase != PH_IDLE);
        r.ch   = seq_samples;
        if (r.done) readouts_done++;
        if (r.tmo) timeouts_seen++;
        tick_results_due.push_back(r);
    endtask

    task automatic report_field(input string what, input logic [23:0] want,
                                input logic [23:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %h got %h", $time, what, want, got);
        end
    endtask

    // Sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                advance_sequencer(s_axis_tdata[0], s_axis_tdata[6:1]);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (ticks_pending.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    s_axis_tdata  <= ticks_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver, with a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end else begin
            if (hold_req)
                hold_left <= HOLD_CYCLES;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
            m_axis_tready <= !(hold_req || hold_left > 1) &&
                             ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        readout_tick_t got;
        readout_tick_t want;
        int k;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[148:0];
            if (tick_results_due.size() == 0) begin
                mismatches++;
                $display("%0t: result with no item pending, expected none got %h",
                         $time, m_axis_tdata);
            end else begin
                want = tick_results_due.pop_front();
                ticks_checked++;
                report_field("serial_clock", 24'(want.sclk), 24'(got.sclk));
                report_field("power_pin", 24'(want.pwr), 24'(got.pwr));
                report_field("busy_res", 24'(want.busy), 24'(got.busy));
                report_field("sample_valid", 24'(want.done), 24'(got.done));
                report_field("ready_timeout", 24'(want.tmo), 24'(got.tmo));
                for (k = 0; k < MAX_CH; k++)
                    report_field($sformatf("sample_ch%0d", k), want.ch[k], got.ch[k]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("%0t: timeout with %0d items pending", $time, tick_results_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_tick(input logic start, input logic [5:0] lines);
        ticks_pending.push_back({1'b0, lines, start});
        ticks_queued++;
    endtask

    task automatic burst(input int n, input logic start, input logic [5:0] lines);
        repeat (n) push_tick(start, lines);
    endtask

    // Idle ticks, a start, n_wait not-ready ticks, then ready and a full readout
    task automatic gen_readout(input int n_wait);
        int shift_len;
        shift_len = 50 * ((cfg_half == 0) ? 1 : int'(cfg_half)) + 2;
        repeat ($urandom_range(3)) push_tick(1'b0, 6'($urandom_range(63)));
        push_tick(1'b1, 6'($urandom_range(63)));
        repeat (n_wait) push_tick(1'($urandom_range(1)), 6'($urandom_range(63)) | 6'h01);
        push_tick(1'($urandom_range(1)), 6'($urandom_range(63)) & 6'h3E);
        repeat (shift_len) push_tick(1'($urandom_range(1)), 6'($urandom_range(63)));
    endtask

    task automatic fill_random(input int n);
        int stop;
        int n_wait;
        stop = ticks_queued + n;
        while (ticks_queued < stop) begin
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(20, 1))
                    push_tick(1'($urandom_range(1)), 6'($urandom_range(63)));
            end else begin
                if (cfg_tmo < 8)
                    n_wait = $urandom_range(int'(cfg_tmo) + 2);
                else
                    n_wait = $urandom_range(4);
                gen_readout(n_wait);
            end
        end
    endtask

    task automatic wait_drained();
        while (ticks_pending.size() != 0 || s_axis_tvalid || tick_results_due.size() != 0)
            @(posedge i_clk);
    endtask

    // Run the sequencer back to idle, then let the pipeline empty
    task automatic settle_idle();
        wait_drained();
        while (seq_phase != PH_IDLE) begin
            burst(64, 1'b0, 6'h00);
            wait_drained();
        end
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_HALF_PERIOD:   cfg_half = val[HALF_W-1:0];
            REG_READY_TIMEOUT: cfg_tmo  = val[TIMEOUT_W-1:0];
            REG_POWER_ENABLE:  cfg_pwr  = val[0];
            default: ;
        endcase
    endtask

    task automatic set_idling(input int snd, input int rcv);
        snd_idle_pct = snd;
        rcv_idle_pct = rcv;
    endtask

    initial begin
        cfg_half     = HALF_RESET;
        cfg_tmo      = TIMEOUT_RESET;
        cfg_pwr      = 1'b1;
        seq_phase    = PH_IDLE;
        seq_pulses   = '0;
        seq_half_tmr = '0;
        seq_wait_tmr = '0;
        seq_clk      = 1'b0;
        seq_samples  = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: all-ones readout with start held, all-zero, alternating
        set_idling(9, 85);
        push_tick(1'b0, 6'h3F);
        push_tick(1'b1, 6'h3F);
        push_tick(1'b1, 6'h00);
        burst(52, 1'b1, 6'h3F);
        push_tick(1'b0, 6'h00);
        burst(52, 1'b0, 6'h00);
        push_tick(1'b1, 6'h00);
        repeat (27) begin
            push_tick(1'b0, 6'h2A);
            push_tick(1'b0, 6'h15);
        end
        fill_random(200);
        settle_idle();

        // Zero timeout, zero half period, power down
        write_reg(REG_READY_TIMEOUT, 24'd0);
        write_reg(REG_HALF_PERIOD, 24'd0);
        write_reg(REG_POWER_ENABLE, 24'd0);
        push_tick(1'b1, 6'h00);
        push_tick(1'b0, 6'h3F);
        push_tick(1'b1, 6'h3F);
        push_tick(1'b0, 6'h3E);
        burst(52, 1'b0, 6'h3E);
        fill_random(200);
        settle_idle();

        set_idling(85, 9);
        write_reg(REG_HALF_PERIOD, 24'd2);
        write_reg(REG_READY_TIMEOUT, 24'd5);
        write_reg(REG_POWER_ENABLE, 24'd1);
        fill_random(200);
        settle_idle();

        write_reg(REG_HALF_PERIOD, 24'd1);
        write_reg(REG_READY_TIMEOUT, 24'hFFFFFF);
        fill_random(200);
        settle_idle();

        // No idling; stall the receiver while items keep coming, then pause the sender
        set_idling(0, 0);
        write_reg(REG_HALF_PERIOD, 24'd3);
        write_reg(REG_READY_TIMEOUT, 24'd2);
        fill_random(150);
        @(posedge i_clk);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        wait_drained();
        fill_random(150);
        settle_idle();

        // Longer half period: one timeout, then one full readout
        write_reg(REG_HALF_PERIOD, 24'd4);
        write_reg(REG_READY_TIMEOUT, 24'd1);
        push_tick(1'b1, 6'h00);
        burst(3, 1'b0, 6'h01);
        gen_readout(1);
        settle_idle();

        repeat (10) @(posedge i_clk);
        if (tick_results_due.size() != 0) mismatches++;
        $display("covered %0d ticks: %0d completed readouts, %0d ready timeouts,",
                 ticks_checked, readouts_done, timeouts_seen);
        $display("half periods 0..4, timeouts 0..16777215, power on and off");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
